>>> rtl/watch_slot_pool_allocator_macros.svh
// assertion macros shared by the slot pool allocator
// used by the top level; no other dependencies
`ifndef WATCH_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define WATCH_SLOT_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define WSPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define WSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wspa_pkg.sv
// shared types and codes for the slot pool allocator
// no dependencies; used by every other file except the macro header
`timescale 1ns / 1ps

package wspa_pkg;

    // pool size default and list output limit
    localparam int DEFAULT_SLOT_COUNT = 32;
    localparam int MAX_RESULTS        = 32;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 5;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ACTIVE  = 2'd3;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_START_FREE,
        OP_START_ACTIVE,
        OP_ALLOC_POP,
        OP_ALLOC_LINK,
        OP_WALK_STEP,
        OP_REL_UNLINK,
        OP_REL_PUSH
    } dp_op_t;

    // source of the slot id in a result word
    typedef enum logic [1:0] {
        ID_ZERO,
        ID_CUR,
        ID_TARGET
    } id_sel_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t              op;
        logic                emit;
        id_sel_t             id_sel;
        logic [STATUS_W-1:0] status;
        logic                last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cur_null;
        logic cur_hit;
        logic link_null;
        logic count_last;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/wspa_req_if.sv
// request channel: command word with valid/ready handshake
// depends on wspa_pkg for field widths
`timescale 1ns / 1ps

interface wspa_req_if import wspa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  slot_number;

    modport source (output valid, output command, output slot_number, input ready);
    modport sink   (input valid, input command, input slot_number, output ready);
endinterface

>>> rtl/wspa_rsp_if.sv
// response channel: result word with valid/ready handshake
// depends on wspa_pkg for field widths
`timescale 1ns / 1ps

interface wspa_rsp_if import wspa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     slot_id;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output slot_id, output status, output last, input ready);
    modport sink   (input valid, input slot_id, input status, input last, output ready);
endinterface

>>> rtl/wspa_ctrl.sv
// controller state machine for the slot pool allocator
// depends on wspa_pkg; drives the datapath through dp_cmd_t
`timescale 1ns / 1ps

module wspa_ctrl import wspa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [CMD_W-1:0] req_command,
    input  dp_stat_t         stat,
    output dp_cmd_t          cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_CHK,
        S_ALLOC_LINK,
        S_REL_WALK,
        S_REL_PUSH,
        S_LIST_WALK,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    id_sel_t             res_id_reg, res_id_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                list_last;

    assign req_ready = (state_reg == S_IDLE);
    assign list_last = stat.link_null | stat.count_last;

    // next state and datapath command
    always_comb
    begin
        state_next      = state_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        cmd.op          = OP_NOP;
        cmd.emit        = 1'b0;
        cmd.id_sel      = ID_ZERO;
        cmd.status      = ST_OK;
        cmd.last        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_command)
                        CMD_ALLOC:
                        begin
                            cmd.op     = OP_START_FREE;
                            state_next = S_ALLOC_CHK;
                        end
                        CMD_RELEASE:
                        begin
                            cmd.op     = OP_START_ACTIVE;
                            state_next = S_REL_WALK;
                        end
                        CMD_LIST:
                        begin
                            cmd.op     = OP_START_ACTIVE;
                            state_next = S_LIST_WALK;
                        end
                        default:
                        begin
                            res_id_next     = ID_ZERO;
                            res_status_next = ST_OK;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end
            S_ALLOC_CHK:
            begin
                if (stat.cur_null)
                begin
                    res_id_next     = ID_ZERO;
                    res_status_next = ST_EXHAUSTED;
                    state_next      = S_EMIT;
                end
                else
                begin
                    cmd.op     = OP_ALLOC_POP;
                    state_next = S_ALLOC_LINK;
                end
            end
            S_ALLOC_LINK:
            begin
                cmd.op          = OP_ALLOC_LINK;
                res_id_next     = ID_CUR;
                res_status_next = ST_OK;
                state_next      = S_EMIT;
            end
            S_REL_WALK:
            begin
                if (stat.cur_null)
                begin
                    res_id_next     = ID_TARGET;
                    res_status_next = ST_NOT_ACTIVE;
                    state_next      = S_EMIT;
                end
                else if (stat.cur_hit)
                begin
                    cmd.op     = OP_REL_UNLINK;
                    state_next = S_REL_PUSH;
                end
                else
                begin
                    cmd.op = OP_WALK_STEP;
                end
            end
            S_REL_PUSH:
            begin
                cmd.op          = OP_REL_PUSH;
                res_id_next     = ID_TARGET;
                res_status_next = ST_OK;
                state_next      = S_EMIT;
            end
            S_LIST_WALK:
            begin
                // empty active list only shows up on the first step
                if (stat.cur_null)
                begin
                    res_id_next     = ID_ZERO;
                    res_status_next = ST_NO_ACTIVE;
                    state_next      = S_EMIT;
                end
                else if (stat.out_free)
                begin
                    cmd.op     = OP_WALK_STEP;
                    cmd.emit   = 1'b1;
                    cmd.id_sel = ID_CUR;
                    cmd.status = ST_OK;
                    cmd.last   = list_last;
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.id_sel = res_id_reg;
                    cmd.status = res_status_reg;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and pending single result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_id_reg     <= ID_ZERO;
            res_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            res_id_reg     <= res_id_next;
            res_status_reg <= res_status_next;
        end
    end

endmodule

>>> rtl/wspa_dp.sv
// datapath: list pointers, link memory with valid bits, result register
// depends on wspa_pkg and wspa_rsp_if; commanded by wspa_ctrl
`timescale 1ns / 1ps

module wspa_dp import wspa_pkg::*;
#(
    parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [ID_W-1:0] req_slot_number,
    input  dp_cmd_t         cmd,
    output dp_stat_t        stat,
    wspa_rsp_if.source      rsp
);

    localparam int ADDR_W     = $clog2(SLOT_COUNT);
    localparam int PTR_W      = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W      = (PTR_W > ID_W) ? PTR_W : ID_W;
    localparam int LIST_LIMIT = (SLOT_COUNT < MAX_RESULTS) ? SLOT_COUNT : MAX_RESULTS;
    localparam int CNT_W      = $clog2(LIST_LIMIT);
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOT_COUNT);

    // list pointers
    logic [PTR_W-1:0] free_head_reg, free_head_next;
    logic [PTR_W-1:0] active_head_reg, active_head_next;
    logic [PTR_W-1:0] active_tail_reg, active_tail_next;

    // walk registers
    logic [PTR_W-1:0] cur_reg, cur_next;
    logic [PTR_W-1:0] prev_reg, prev_next;
    logic [ID_W-1:0]  target_reg, target_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // link memory, one write and one registered read per cycle
    logic [PTR_W-1:0]      link_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] link_valid_reg;
    logic [PTR_W-1:0]      rd_data_reg;
    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [PTR_W-1:0]      wr_data;
    logic [PTR_W-1:0]      link_val;

    // result register
    logic                rsp_valid_reg;
    logic [ID_W-1:0]     slot_id_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;
    logic [ID_W-1:0]     id_word;
    logic [CMP_W-1:0]    cur_ext;
    logic                act_empty;
    logic                out_free;

    // an entry never written holds its reset link, which is always its index plus one
    assign link_val  = rd_valid_reg ? rd_data_reg : (PTR_W'(rd_addr_reg) + PTR_W'(1));
    assign rd_addr   = cur_next[ADDR_W-1:0];
    assign act_empty = (active_head_reg == NULL_PTR) || (active_tail_reg == NULL_PTR);
    assign cur_ext   = CMP_W'(cur_reg);
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // status to the controller
    assign stat.cur_null   = (cur_reg == NULL_PTR);
    assign stat.cur_hit    = (cur_ext == CMP_W'(target_reg));
    assign stat.link_null  = (link_val == NULL_PTR);
    assign stat.count_last = (count_reg == CNT_W'(LIST_LIMIT - 1));
    assign stat.out_free   = out_free;

    // list operations
    always_comb
    begin
        free_head_next   = free_head_reg;
        active_head_next = active_head_reg;
        active_tail_next = active_tail_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        target_next      = target_reg;
        count_next       = count_reg;
        wr_en            = 1'b0;
        wr_addr          = cur_reg[ADDR_W-1:0];
        wr_data          = NULL_PTR;
        case (cmd.op)
            OP_START_FREE:
            begin
                cur_next    = free_head_reg;
                prev_next   = NULL_PTR;
                target_next = req_slot_number;
                count_next  = '0;
            end
            OP_START_ACTIVE:
            begin
                cur_next    = active_head_reg;
                prev_next   = NULL_PTR;
                target_next = req_slot_number;
                count_next  = '0;
            end
            OP_ALLOC_POP:
            begin
                free_head_next = link_val;
                wr_en          = 1'b1;
                wr_addr        = cur_reg[ADDR_W-1:0];
                wr_data        = NULL_PTR;
            end
            OP_ALLOC_LINK:
            begin
                if (act_empty)
                begin
                    active_head_next = cur_reg;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = active_tail_reg[ADDR_W-1:0];
                    wr_data = cur_reg;
                end
                active_tail_next = cur_reg;
            end
            OP_WALK_STEP:
            begin
                prev_next  = cur_reg;
                cur_next   = link_val;
                count_next = count_reg + CNT_W'(1);
            end
            OP_REL_UNLINK:
            begin
                if (prev_reg == NULL_PTR)
                begin
                    active_head_next = link_val;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = prev_reg[ADDR_W-1:0];
                    wr_data = link_val;
                end
                if (active_tail_reg == cur_reg)
                begin
                    active_tail_next = prev_reg;
                end
            end
            OP_REL_PUSH:
            begin
                wr_en          = 1'b1;
                wr_addr        = cur_reg[ADDR_W-1:0];
                wr_data        = free_head_reg;
                free_head_next = cur_reg;
            end
            default:
            begin
            end
        endcase
    end

    // slot id of the result word
    always_comb
    begin
        case (cmd.id_sel)
            ID_CUR:    id_word = cur_ext[ID_W-1:0];
            ID_TARGET: id_word = target_reg;
            default:   id_word = '0;
        endcase
    end

    // list pointers, valid bits and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg   <= '0;
            active_head_reg <= NULL_PTR;
            active_tail_reg <= NULL_PTR;
            link_valid_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            free_head_reg   <= free_head_next;
            active_head_reg <= active_head_next;
            active_tail_reg <= active_tail_next;
            if (wr_en)
            begin
                link_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= link_mem[rd_addr];
        rd_valid_reg <= link_valid_reg[rd_addr];
        rd_addr_reg  <= rd_addr;
    end

    // walk registers and result payload
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        target_reg <= target_next;
        count_reg  <= count_next;
        if (cmd.emit)
        begin
            slot_id_reg <= id_word;
            status_reg  <= cmd.status;
            last_reg    <= cmd.last;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.slot_id = slot_id_reg;
    assign rsp.status  = status_reg;
    assign rsp.last    = last_reg;

endmodule

>>> rtl/watch_slot_pool_allocator.sv
// Slot pool allocator: free list and allocation-ordered active list over one link memory.
// Allocate pops the free head and links it onto the active tail, or reports exhausted.
// Release walks the active list from the head to the named slot, unlinks it and pushes it
// onto the free stack, or reports not active. List emits one word per active slot, head to
// tail, up to the list output limit, or one no-active word for an empty list. The unused
// code returns one OK word for slot zero; results wait while the output register is full.
// Walks read one link per cycle from the link memory through a registered read, the list
// walk only while the output register is free. Per-entry valid bits stand in for the reset
// image, so no clearing pass. Commands are taken one at a time; a result word may still wait
// on the output register while the next command word is accepted.
// Depends on wspa_pkg, wspa_req_if, wspa_rsp_if, wspa_ctrl, wspa_dp and the macro header.
`timescale 1ns / 1ps
`include "watch_slot_pool_allocator_macros.svh"

module watch_slot_pool_allocator import wspa_pkg::*;
#(
    parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
)
(
    input  logic       clk,
    input  logic       rst_n,
    wspa_req_if.sink   req,
    wspa_rsp_if.source rsp
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // controller
    wspa_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_command (req.command),
        .stat        (dp_stat),
        .cmd         (dp_cmd)
    );

    // datapath
    wspa_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_slot_number (req.slot_number),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .rsp             (rsp)
    );

    // a new command is never taken while a non-final word of a list is pending
    `WSPA_ASSERT_NOW(a_idle_no_partial, clk, rst_n, req.ready, !(rsp.valid && !rsp.last), "command ready while list output unfinished")
    // the controller only loads the result register when it is free
    `WSPA_ASSERT_NOW(a_emit_when_free, clk, rst_n, dp_cmd.emit, dp_stat.out_free, "result word loaded over a pending word")
    // one command at a time
    `WSPA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, !req.ready, "ready stayed high after a command word")

endmodule

>>> sim/wspa_checker.sv
// checker for the slot pool allocator: watches both channels, predicts result words
// from its own copy of the free and active lists, and compares them in order
// depends on wspa_pkg for field widths, command and status codes
`timescale 1ns / 1ps

module wspa_checker import wspa_pkg::*;
#(
    parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  logic [CMD_W-1:0]      req_command,
    input  logic [ID_W-1:0]       req_slot_number,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  logic [ID_W-1:0]       rsp_slot_id,
    input  logic [STATUS_W-1:0]   rsp_status,
    input  logic                  rsp_last,
    output int                    fail_count,
    output int                    awaited_count,
    output int                    checked_count,
    output logic [SLOT_COUNT-1:0] active_slots
);

    localparam int LINK_W = $clog2(SLOT_COUNT + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOT_COUNT);
    localparam int REPORT_MAX = 40;

    typedef struct packed {
        logic [ID_W-1:0]     slot_id;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_word_t;

    // shadow of the pool: one link table shared by the free stack and the active list
    logic [LINK_W-1:0] next_link [SLOT_COUNT];
    logic [LINK_W-1:0] free_head;
    logic [LINK_W-1:0] active_head;
    logic [LINK_W-1:0] active_tail;
    result_word_t      awaited_q [$];

    function automatic result_word_t word_of(input logic [ID_W-1:0] id,
                                             input logic [STATUS_W-1:0] st,
                                             input logic lst);
        result_word_t w;
        w.slot_id = id;
        w.status  = st;
        w.last    = lst;
        return w;
    endfunction

    task automatic reset_pool();
        for (int i = 0; i < SLOT_COUNT; i++)
            next_link[i] = LINK_W'(i + 1);
        next_link[SLOT_COUNT-1] = NULL_LINK;
        free_head     = '0;
        active_head   = NULL_LINK;
        active_tail   = NULL_LINK;
        active_slots  = '0;
        awaited_q.delete();
        fail_count    = 0;
        awaited_count = 0;
        checked_count = 0;
    endtask

    // apply one command word to the shadow pool and queue the words it causes
    task automatic predict_command(input logic [CMD_W-1:0] cmd,
                                   input logic [ID_W-1:0] target);
        logic [LINK_W-1:0] s;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] tgt;
        logic              found;
        int                steps;
        int                n;
        tgt = LINK_W'(target);
        case (cmd)
            CMD_ALLOC:
            begin
                if (free_head >= NULL_LINK)
                    awaited_q.push_back(word_of('0, ST_EXHAUSTED, 1'b1));
                else
                begin
                    s                = free_head;
                    free_head        = next_link[s];
                    next_link[s]     = NULL_LINK;
                    if (active_head >= NULL_LINK || active_tail >= NULL_LINK)
                        active_head = s;
                    else
                        next_link[active_tail] = s;
                    active_tail      = s;
                    active_slots[s]  = 1'b1;
                    awaited_q.push_back(word_of(ID_W'(s), ST_OK, 1'b1));
                end
            end
            CMD_RELEASE:
            begin
                // walk the active list looking for the named slot
                prev  = NULL_LINK;
                cur   = active_head;
                found = 1'b0;
                steps = 0;
                while (!found && steps < SLOT_COUNT && cur < NULL_LINK)
                begin
                    if (cur == tgt)
                        found = 1'b1;
                    else
                    begin
                        prev = cur;
                        cur  = next_link[cur];
                        steps++;
                    end
                end
                if (found)
                begin
                    if (prev >= NULL_LINK)
                        active_head = next_link[cur];
                    else
                        next_link[prev] = next_link[cur];
                    if (active_tail == cur)
                        active_tail = prev;
                    next_link[cur]    = free_head;
                    free_head         = cur;
                    active_slots[cur] = 1'b0;
                    awaited_q.push_back(word_of(target, ST_OK, 1'b1));
                end
                else
                    awaited_q.push_back(word_of(target, ST_NOT_ACTIVE, 1'b1));
            end
            CMD_LIST:
            begin
                if (active_head >= NULL_LINK)
                    awaited_q.push_back(word_of('0, ST_NO_ACTIVE, 1'b1));
                else
                begin
                    // emit head to tail, capped at the list output limit
                    cur = active_head;
                    n   = 0;
                    while (cur < NULL_LINK && n < MAX_RESULTS && n < SLOT_COUNT)
                    begin
                        s = next_link[cur];
                        awaited_q.push_back(word_of(ID_W'(cur), ST_OK,
                            s >= NULL_LINK || n == MAX_RESULTS - 1 || n == SLOT_COUNT - 1));
                        cur = s;
                        n++;
                    end
                end
            end
            default:
                awaited_q.push_back(word_of('0, ST_OK, 1'b1));
        endcase
    endtask

    // compare result words first, then predict from the command word of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
            reset_pool();
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                checked_count++;
                if (awaited_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: unexpected word: expected none, actual slot_id %0d status %0d last %0d",
                                 $time, rsp_slot_id, rsp_status, rsp_last);
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (want.slot_id !== rsp_slot_id || want.status !== rsp_status ||
                        want.last !== rsp_last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("%0t: word mismatch: expected slot_id %0d status %0d last %0d, actual slot_id %0d status %0d last %0d",
                                     $time, want.slot_id, want.status, want.last,
                                     rsp_slot_id, rsp_status, rsp_last);
                    end
                end
            end
            if (req_valid && req_ready)
                predict_command(req_command, req_slot_number);
            awaited_count = awaited_q.size();
        end
    end

endmodule

>>> sim/watch_slot_pool_allocator_tb.sv
// top of the slot pool allocator testbench: clock, reset, command stimulus,
// response stalls, watchdog and verdict
// depends on wspa_pkg, wspa_req_if, wspa_rsp_if, wspa_checker and the block itself
`timescale 1ns / 1ps

module watch_slot_pool_allocator_tb;
    import wspa_pkg::*;

    localparam int SLOT_COUNT   = DEFAULT_SLOT_COUNT;
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_WORDS = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    // the command code the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    wspa_req_if req_ch ();
    wspa_rsp_if rsp_ch ();

    int                    fail_count;
    int                    awaited_count;
    int                    checked_count;
    logic [SLOT_COUNT-1:0] active_slots;

    int words_sent   = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    int cmd_tally [4];
    bit steady_send  = 1'b0;
    bit steady_take  = 1'b0;

    watch_slot_pool_allocator #(.SLOT_COUNT(SLOT_COUNT)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    wspa_checker #(.SLOT_COUNT(SLOT_COUNT)) pool_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_ch.valid),
        .req_ready       (req_ch.ready),
        .req_command     (req_ch.command),
        .req_slot_number (req_ch.slot_number),
        .rsp_valid       (rsp_ch.valid),
        .rsp_ready       (rsp_ch.ready),
        .rsp_slot_id     (rsp_ch.slot_id),
        .rsp_status      (rsp_ch.status),
        .rsp_last        (rsp_ch.last),
        .fail_count      (fail_count),
        .awaited_count   (awaited_count),
        .checked_count   (checked_count),
        .active_slots    (active_slots)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // mostly a slot that is active now, otherwise any slot number
    function automatic logic [ID_W-1:0] pick_release();
        int start;
        int idx;
        if (active_slots != '0 && $urandom_range(0, 99) < 85)
        begin
            start = $urandom_range(0, SLOT_COUNT - 1);
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                idx = (start + i) % SLOT_COUNT;
                if (active_slots[idx])
                    return ID_W'(idx);
            end
        end
        return ID_W'($urandom);
    endfunction

    // response stalls, with stretches of steady acceptance
    initial rsp_ch.ready = 1'b0;
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            steady_take = ~steady_take;
        if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (!steady_take)
                stall_left = gap_length();
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout, no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // present one command word, hold until taken, then maybe leave a gap
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] slot);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.slot_number <= slot;
        do
            @(posedge clk);
        while (!req_ch.ready);
        words_sent++;
        cmd_tally[cmd]++;
        @(negedge clk);
        gap = steady_send ? 0 : gap_length();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // stop sending until every predicted word has come back
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (awaited_count != 0)
            @(negedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        int r;
        int target_words;
        for (int i = 0; i < 4; i++)
            cmd_tally[i] = 0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.command     = CMD_ALLOC;
        req_ch.slot_number = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty pool cases, unused code, head/middle/tail release, free stack order
        send_word(CMD_LIST,    5'd0);
        send_word(CMD_RELEASE, 5'd0);
        send_word(CMD_RELEASE, 5'd31);
        send_word(CMD_UNUSED,  5'd31);
        send_word(CMD_ALLOC,   5'd31);
        send_word(CMD_ALLOC,   5'd0);
        send_word(CMD_ALLOC,   5'd21);
        send_word(CMD_ALLOC,   5'd10);
        send_word(CMD_LIST,    5'd31);
        send_word(CMD_RELEASE, 5'd31);
        send_word(CMD_RELEASE, 5'd2);
        send_word(CMD_RELEASE, 5'd0);
        send_word(CMD_RELEASE, 5'd3);
        send_word(CMD_RELEASE, 5'd3);
        send_word(CMD_LIST,    5'd0);
        send_word(CMD_ALLOC,   5'd0);
        send_word(CMD_ALLOC,   5'd0);
        send_word(CMD_LIST,    5'd0);
        send_word(CMD_RELEASE, 5'd1);
        send_word(CMD_UNUSED,  5'd0);
        send_word(CMD_LIST,    5'd0);
        hold_until_drained();

        // random phases: fill to exhaustion, drain to empty, or a mixed run
        target_words = words_sent + RANDOM_WORDS;
        while (words_sent < target_words)
        begin
            steady_send = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:
                begin
                    while (active_slots != '1)
                        send_word(CMD_ALLOC, ID_W'($urandom));
                    repeat ($urandom_range(1, 3))
                        send_word(CMD_ALLOC, ID_W'($urandom));
                    send_word(CMD_LIST, ID_W'($urandom));
                end
                1:
                begin
                    while (active_slots != '0)
                        send_word(CMD_RELEASE, pick_release());
                    send_word(CMD_RELEASE, ID_W'($urandom));
                    send_word(CMD_LIST, ID_W'($urandom));
                end
                default:
                begin
                    repeat ($urandom_range(10, 40))
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 40)
                            send_word(CMD_ALLOC, ID_W'($urandom));
                        else if (r < 75)
                            send_word(CMD_RELEASE, pick_release());
                        else if (r < 93)
                            send_word(CMD_LIST, ID_W'($urandom));
                        else
                            send_word(CMD_UNUSED, ID_W'($urandom));
                    end
                end
            endcase
            if ($urandom_range(0, 5) == 0)
                hold_until_drained();
        end

        // let the last results come, then allow the longest walk to finish
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d command words: %0d allocate, %0d release, %0d list, %0d unused code",
                 words_sent, cmd_tally[CMD_ALLOC], cmd_tally[CMD_RELEASE],
                 cmd_tally[CMD_LIST], cmd_tally[CMD_UNUSED]);
        $display("checked %0d result words, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0 && awaited_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
